/* rtl/core/wrt_pkg.sv */
// ----------------------------------------------------------------------------
// wrt_pkg: shared types and constants of the watch range table
// Request and status codes, the queued item record and the default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package wrt_pkg;

	localparam int unsigned WRT_ENTRIES = 16;
	localparam int unsigned ADDR_W      = 32;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} wrt_op_t;

	typedef enum logic [1:0] {
		STS_OK     = 2'd0,
		STS_FULL   = 2'd1,
		STS_DUP    = 2'd2,
		STS_ABSENT = 2'd3
	} wrt_status_t;

	// one classified item as it waits between front and back
	typedef struct packed {
		wrt_op_t             op;
		logic                scan;
		logic [ADDR_W-1:0]   addr;
		logic [ADDR_W-1:0]   size;
	} wrt_item_t;

endpackage

`default_nettype wire

/* rtl/core/wrt_req_if.sv */
// ----------------------------------------------------------------------------
// wrt_req_if: request channel of the watch range table
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [31:0] addr;
	logic [31:0] size_bytes;

	modport source (output valid, output req_type, output addr, output size_bytes,
		input ready);
	modport sink (input valid, input req_type, input addr, input size_bytes,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/wrt_rsp_if.sv */
// ----------------------------------------------------------------------------
// wrt_rsp_if: result channel of the watch range table
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrt_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [31:0] match_start;
	logic [1:0]  status;

	modport source (output valid, output hit, output match_start, output status,
		input ready);
	modport sink (input valid, input hit, input match_start, input status,
		output ready);
endinterface

`default_nettype wire

/* rtl/core/wrt_ram.sv */
// ----------------------------------------------------------------------------
// wrt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/wrt_front.sv */
// ----------------------------------------------------------------------------
// wrt_front: request intake of the watch range table
// Decodes each request and holds up to two items for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_front (
	input  wire logic       clk,
	input  wire logic       arst_n,
	wrt_req_if.sink         req,
	output logic            q_valid,
	output wrt_pkg::wrt_item_t q_item,
	input  wire logic       q_pop
);
	import wrt_pkg::*;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned PW     = $clog2(QDEPTH);

	wrt_item_t         slot_q [QDEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       cnt_q;
	wrt_item_t         item_in;
	logic              push;

	// classify: clear needs no pass over the table
	always_comb begin
		item_in.op   = wrt_op_t'(req.req_type);
		item_in.addr = req.addr;
		item_in.size = req.size_bytes;
		unique case (item_in.op)
			OP_CLEAR: item_in.scan = 1'b0;
			default:  item_in.scan = 1'b1;
		endcase
	end

	assign req.ready = (cnt_q != (PW+1)'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/wrt_back.sv */
// ----------------------------------------------------------------------------
// wrt_back: table engine of the watch range table
// Scans the range RAM one entry per cycle, then updates and reports.
// ----------------------------------------------------------------------------
`default_nettype none

module wrt_back #(
	parameter int unsigned ENTRIES = wrt_pkg::WRT_ENTRIES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire wrt_pkg::wrt_item_t q_item,
	output logic            q_pop,
	wrt_rsp_if.source       rsp
);
	import wrt_pkg::*;

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t                 state_q;
	wrt_item_t              cur_q;
	logic [ENTRIES-1:0]     valid_q;
	logic [IDX_W-1:0]       rd_idx_q;

	logic                   vld_s1;
	logic                   ent_vld_s1;
	logic [IDX_W-1:0]       idx_s1;

	logic                   found_q;
	logic [IDX_W-1:0]       found_idx_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   hit_q;
	logic [ADDR_W-1:0]      match_q;

	logic                   out_vld_q;
	logic                   out_hit_q;
	logic [ADDR_W-1:0]      out_match_q;
	wrt_status_t            out_status_q;

	logic [2*ADDR_W-1:0]    rdata;
	logic [ADDR_W-1:0]      ent_start;
	logic [ADDR_W-1:0]      ent_len;
	logic [ADDR_W:0]        ent_end;
	logic                   in_range;
	logic                   can_finish;
	logic                   ram_we;
	wrt_status_t            fin_status;

	assign ent_start  = rdata[2*ADDR_W-1:ADDR_W];
	assign ent_len    = rdata[ADDR_W-1:0];
	assign ent_end    = {1'b0, ent_start} + {1'b0, ent_len};
	assign in_range   = (cur_q.addr >= ent_start) && ({1'b0, cur_q.addr} < ent_end);
	assign can_finish = !out_vld_q || rsp.ready;
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign ram_we     = (state_q == S_FINISH) && can_finish && (cur_q.op == OP_ADD)
		&& !found_q && free_q;

	always_comb begin
		fin_status = STS_OK;
		unique case (cur_q.op)
			OP_ADD: begin
				if (found_q) begin
					fin_status = STS_DUP;
				end else if (!free_q) begin
					fin_status = STS_FULL;
				end
			end
			OP_REMOVE: begin
				if (!found_q) begin
					fin_status = STS_ABSENT;
				end
			end
			default: fin_status = STS_OK;
		endcase
	end

	wrt_ram #(
		.WIDTH (2*ADDR_W),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (free_idx_q),
		.wdata ({cur_q.addr, cur_q.size}),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign rsp.valid       = out_vld_q;
	assign rsp.hit         = out_hit_q;
	assign rsp.match_start = out_match_q;
	assign rsp.status      = out_status_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_item;
		end
		if ((state_q == S_FINISH) && can_finish) begin
			out_hit_q    <= (cur_q.op == OP_LOOKUP) && hit_q;
			out_match_q  <= (cur_q.op == OP_LOOKUP) ? match_q : '0;
			out_status_q <= fin_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			ent_vld_s1  <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			hit_q       <= 1'b0;
			match_q     <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			// read pipeline: RAM data lines up with the _s1 flags
			vld_s1     <= (state_q == S_SCAN);
			ent_vld_s1 <= valid_q[rd_idx_q];
			idx_s1     <= rd_idx_q;

			if (vld_s1) begin
				if (ent_vld_s1) begin
					if (ent_start == cur_q.addr) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_s1;
					end
					if (in_range && (!hit_q || (ent_start < match_q))) begin
						hit_q   <= 1'b1;
						match_q <= ent_start;
					end
				end else if (!free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						found_q  <= 1'b0;
						free_q   <= 1'b0;
						hit_q    <= 1'b0;
						match_q  <= '0;
						rd_idx_q <= '0;
						state_q  <= q_item.scan ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (rd_idx_q == IDX_W'(ENTRIES-1)) begin
						state_q <= S_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (can_finish) begin
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
						unique case (cur_q.op)
							OP_ADD: begin
								if (!found_q && free_q) begin
									valid_q[free_idx_q] <= 1'b1;
								end
							end
							OP_REMOVE: begin
								if (found_q) begin
									valid_q[found_idx_q] <= 1'b0;
								end
							end
							OP_CLEAR: valid_q <= '0;
							default: ;
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/watch_range_table.sv */
// ----------------------------------------------------------------------------
// watch_range_table: table of watched address ranges keyed by start address
// Add, remove, lookup and clear requests, one result per request.
// ----------------------------------------------------------------------------
// Requests enter on req (valid/ready) and are decoded into a two-item queue;
// results leave on rsp (valid/ready), one per request, in request order.
// Add, remove and lookup pass over every slot of the range RAM, one slot a
// cycle through its single read port: the engine takes the request, reads
// every slot, drains the read pipeline and reports. Clear skips the pass
// and goes straight from take to report. The engine works on one request
// at a time; the queue accepts further requests while it is busy.
// Lookup reports the covering range with the smallest start, the end taken
// 33 bits wide so that a range never wraps.
// Reset empties the table (all slot valid bits cleared at once) and the
// queue; the block takes requests in the first cycle after reset.
// While rsp is stalled the finished result holds in the output register,
// the engine holds its next report, and req keeps accepting until the
// queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module watch_range_table #(
	parameter int unsigned ENTRIES = wrt_pkg::WRT_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	wrt_req_if.sink   req,
	wrt_rsp_if.source rsp
);
	import wrt_pkg::*;

	logic      q_valid;
	logic      q_pop;
	wrt_item_t q_item;

	wrt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	wrt_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire
